@@ rtl/mwsb_pkg.sv @@
// Shared types and sizes for the moving-window sum buffer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mwsb_pkg;

	localparam int DEPTH       = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int LAG_BITS    = 6;
	localparam int FILL_BITS   = $clog2(DEPTH + 1);
	localparam int SUM_BITS    = 22;
	localparam int GROUP_SIZE  = 8;
	localparam int GROUP_COUNT = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;
	typedef logic [FILL_BITS-1:0]          fill_t;
	typedef logic [LAG_BITS-1:0]           lag_t;

	// Window status that travels with each beat toward the output
	typedef struct packed {
		sum_t  sum;
		fill_t fill;
	} meta_t;

endpackage

@@ rtl/mwsb_if.sv @@
// Handshake channels of the moving-window sum buffer: item in, result out.
// Depends on mwsb_pkg.
`timescale 1ns / 1ps

interface mwsb_in_if;
	import mwsb_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  func;
	sample_t     sample;
	lag_t        lag;

	modport source (output valid, func, sample, lag, input ready);
	modport sink   (input valid, func, sample, lag, output ready);
endinterface

interface mwsb_out_if;
	import mwsb_pkg::*;

	logic        valid;
	logic        ready;
	sum_t        window_sum;
	sample_t     picked_value;
	fill_t       fill_count;

	modport source (output valid, window_sum, picked_value, fill_count, input ready);
	modport sink   (input valid, window_sum, picked_value, fill_count, output ready);
endinterface

@@ rtl/mwsb_cell.sv @@
// One cell of the sample shift line: holds one sample, hands it on at a push,
// and drives its sample onto the read bus when the lag names it. Uses mwsb_pkg.
`timescale 1ns / 1ps

module mwsb_cell (
	input  logic             clk,
	input  logic             shift_en,
	input  mwsb_pkg::sample_t din,
	output mwsb_pkg::sample_t dout,
	input  mwsb_pkg::lag_t    idx,
	input  mwsb_pkg::lag_t    lag,
	input  logic             rd_en,
	output logic             hit,
	output mwsb_pkg::sample_t pick
);
	import mwsb_pkg::*;

	sample_t sample_q;

	// advance the line by one place on a push
	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= din;
		end
	end

	assign dout = sample_q;

	// drive the read bus only when this cell is the requested lag
	assign hit  = rd_en && (idx == lag);
	assign pick = hit ? sample_q : '0;

endmodule

@@ rtl/mwsb_out_pipe.sv @@
// Result pipeline: folds the cell read bus in two registered steps and holds
// the result beat until taken. Uses mwsb_pkg and mwsb_out_if.
`timescale 1ns / 1ps

module mwsb_out_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  mwsb_pkg::meta_t   meta,
	input  mwsb_pkg::sample_t picks [mwsb_pkg::DEPTH],
	output logic              ready,
	mwsb_out_if.source        result
);
	import mwsb_pkg::*;

	sample_t part [GROUP_COUNT];
	sample_t part_s1 [GROUP_COUNT];
	meta_t   meta_s1;
	logic    valid_s1;
	logic    out_valid_q;
	sum_t    sum_q;
	sample_t pick_q;
	fill_t   fill_q;
	sample_t pick_all;
	logic    adv;

	// fold each group of cells; at most one cell drives nonzero
	always_comb begin
		for (int g = 0; g < GROUP_COUNT; g++) begin
			part[g] = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (g * GROUP_SIZE + k < DEPTH) begin
					part[g] = part[g] | picks[g * GROUP_SIZE + k];
				end
			end
		end
	end

	always_comb begin
		pick_all = '0;
		for (int g = 0; g < GROUP_COUNT; g++) begin
			pick_all = pick_all | part_s1[g];
		end
	end

	assign adv   = !out_valid_q || result.ready;
	assign ready = !valid_s1 || adv;

	// first stage: group partials and window status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && take) begin
			meta_s1 <= meta;
			part_s1 <= part;
		end
	end

	// output register: hold while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			sum_q  <= meta_s1.sum;
			fill_q <= meta_s1.fill;
			pick_q <= pick_all;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.window_sum   = sum_q;
	assign result.picked_value = pick_q;
	assign result.fill_count   = fill_q;

endmodule

@@ rtl/moving_window_sum_buffer.sv @@
// Top level of the moving-window sum buffer: shift line of sample cells,
// running sum and fill count, result pipeline. Uses mwsb_pkg, mwsb_if,
// mwsb_cell and mwsb_out_pipe.
//
//   channel  dir  handshake     payload
//   item     in   valid/ready   func, sample, lag
//   result   out  valid/ready   window_sum, picked_value, fill_count
//
// Items are accepted one per cycle while ready is high.
// A push shifts all 64 cells at once and updates the sum in the accept cycle.
// The read bus is folded over two registered steps, which sets the latency.
// Reset clears the sum, the fill count and the pipeline valids; cells are not
// cleared, reads never reach a cell beyond the fill count.
// When the result sink stalls, ready drops only once both stages hold a beat.
`timescale 1ns / 1ps

module moving_window_sum_buffer (
	input  logic        clk,
	input  logic        arst_n,
	mwsb_in_if.sink     item,
	mwsb_out_if.source  result
);
	import mwsb_pkg::*;

	logic    accept;
	logic    is_push;
	logic    is_read;
	logic    is_clear;
	logic    full;
	logic    rd_en;
	logic    pipe_ready;
	sum_t    sum_q;
	sum_t    sum_nxt;
	fill_t   fill_q;
	fill_t   fill_nxt;
	meta_t   meta;
	sample_t chain [DEPTH+1];
	sample_t picks [DEPTH];
	logic [DEPTH-1:0] hits;

	assign accept   = item.valid && item.ready;
	assign is_push  = accept && (item.func == FUNC_PUSH);
	assign is_read  = accept && (item.func == FUNC_READ);
	assign is_clear = accept && (item.func == FUNC_CLEAR);
	assign full     = (fill_q == FILL_BITS'(DEPTH));
	assign rd_en    = is_read && (FILL_BITS'(item.lag) < fill_q);

	// newest sample enters at cell 0, the oldest leaves past the last cell
	assign chain[0] = item.sample;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		mwsb_cell u_cell (
			.clk      (clk),
			.shift_en (is_push),
			.din      (chain[i]),
			.dout     (chain[i+1]),
			.idx      (LAG_BITS'(i)),
			.lag      (item.lag),
			.rd_en    (rd_en),
			.hit      (hits[i]),
			.pick     (picks[i])
		);
	end

	// next window sum and fill count
	always_comb begin
		sum_nxt  = sum_q;
		fill_nxt = fill_q;
		if (accept) begin
			case (item.func)
				FUNC_PUSH: begin
					sum_nxt = sum_q + SUM_BITS'(item.sample)
						- (full ? SUM_BITS'(chain[DEPTH]) : SUM_BITS'(0));
					fill_nxt = full ? fill_q : fill_q + 1'b1;
				end
				FUNC_CLEAR: begin
					sum_nxt  = '0;
					fill_nxt = '0;
				end
				default: begin
					sum_nxt  = sum_q;
					fill_nxt = fill_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			fill_q <= '0;
		end else begin
			sum_q  <= sum_nxt;
			fill_q <= fill_nxt;
		end
	end

	assign meta.sum  = sum_nxt;
	assign meta.fill = fill_nxt;

	mwsb_out_pipe u_out_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (accept),
		.meta   (meta),
		.picks  (picks),
		.ready  (pipe_ready),
		.result (result)
	);

	assign item.ready = pipe_ready;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_BITS'(DEPTH))
		else $error("fill count beyond window depth");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hits))
		else $error("more than one cell drives the read bus");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		is_clear |=> (fill_q == '0) && (sum_q == '0))
		else $error("clear did not empty the window");

	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		is_push && !full |=> fill_q == $past(fill_q) + 1'b1)
		else $error("push did not advance the fill count");

	a_hit_needs_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(hits != '0) |-> (FILL_BITS'(item.lag) < fill_q))
		else $error("read hit past the filled part of the window");
`endif

endmodule
